### hdl/scws_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// scws_pkg
// Shared types and constants of the source comment and whitespace stripper.
// ----------------------------------------------------------------------------
package scws_pkg;

   // Lexer modes
   localparam logic [1:0] MODE_NORMAL = 2'd0;
   localparam logic [1:0] MODE_QUOTE  = 2'd1;
   localparam logic [1:0] MODE_LINE   = 2'd2;
   localparam logic [1:0] MODE_BLOCK  = 2'd3;

   // Result kinds
   localparam logic [1:0] KIND_CHAR   = 2'd0;
   localparam logic [1:0] KIND_END_OK = 2'd1;
   localparam logic [1:0] KIND_END_ERR = 2'd2;

   // Character codes
   localparam logic [7:0] CH_SLASH  = 8'h2F;
   localparam logic [7:0] CH_STAR   = 8'h2A;
   localparam logic [7:0] CH_BSLASH = 8'h5C;
   localparam logic [7:0] CH_SQUOTE = 8'h27;
   localparam logic [7:0] CH_DQUOTE = 8'h22;
   localparam logic [7:0] CH_SPACE  = 8'h20;
   localparam logic [7:0] CH_TAB    = 8'h09;
   localparam logic [7:0] CH_CR     = 8'h0D;
   localparam logic [7:0] CH_LF     = 8'h0A;

   localparam int MAX_RESULTS = 3;

   // Results caused by one input item; cnt is 1..3 when the bundle is queued.
   typedef struct packed {
      logic [1:0]                    cnt;
      logic [MAX_RESULTS-1:0][7:0]   ch;
      logic [MAX_RESULTS-1:0][1:0]   kind;
   } bundle_type;

endpackage

### hdl/scws_front.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// scws_front
// Lexer state and per-character classification into a result bundle.
// ----------------------------------------------------------------------------
module scws_front (
   input  logic                clock,
   input  logic                reset,
   input  logic                accept,
   input  logic [7:0]          character,
   input  logic                final_char,
   output logic                bundle_valid,
   output scws_pkg::bundle_type bundle
);
   import scws_pkg::*;

   logic [1:0] mode_ff, mode_in;
   logic [7:0] quote_ff, quote_in;
   logic       esc_ff, esc_in;
   logic       slash_ff, slash_in;
   logic       star_ff, star_in;

   always_comb begin
      logic [1:0] n;
      logic       do_normal;
      n         = 2'd0;
      do_normal = 1'b0;
      bundle    = '0;
      mode_in   = mode_ff;
      quote_in  = quote_ff;
      esc_in    = esc_ff;
      slash_in  = slash_ff;
      star_in   = star_ff;

      unique case (mode_ff)
         MODE_QUOTE: begin
            bundle.ch[n]   = character;
            bundle.kind[n] = KIND_CHAR;
            n = n + 2'd1;
            if (esc_ff) begin
               esc_in = 1'b0;
            end else if (character == CH_BSLASH) begin
               esc_in = 1'b1;
            end else if (character == quote_ff) begin
               mode_in  = MODE_NORMAL;
               quote_in = 8'd0;
            end
         end
         MODE_LINE: begin
            if (character == CH_LF) begin
               mode_in = MODE_NORMAL;
            end
         end
         MODE_BLOCK: begin
            if (star_ff && character == CH_SLASH) begin
               mode_in = MODE_NORMAL;
               star_in = 1'b0;
            end else begin
               star_in = (character == CH_STAR);
            end
         end
         default: begin
            if (slash_ff) begin
               slash_in = 1'b0;
               if (character == CH_SLASH) begin
                  mode_in = MODE_LINE;
               end else if (character == CH_STAR) begin
                  mode_in = MODE_BLOCK;
                  star_in = 1'b0;
               end else begin
                  // held slash was not a comment opener
                  bundle.ch[n]   = CH_SLASH;
                  bundle.kind[n] = KIND_CHAR;
                  n = n + 2'd1;
                  do_normal = 1'b1;
               end
            end else begin
               do_normal = 1'b1;
            end
         end
      endcase

      if (do_normal) begin
         if (character == CH_SQUOTE || character == CH_DQUOTE) begin
            mode_in  = MODE_QUOTE;
            quote_in = character;
            esc_in   = 1'b0;
            bundle.ch[n]   = character;
            bundle.kind[n] = KIND_CHAR;
            n = n + 2'd1;
         end else if (character == CH_SLASH) begin
            slash_in = 1'b1;
         end else if (!(character == CH_SPACE || character == CH_TAB ||
                        character == CH_CR || character == CH_LF)) begin
            bundle.ch[n]   = character;
            bundle.kind[n] = KIND_CHAR;
            n = n + 2'd1;
         end
      end

      if (final_char) begin
         if (slash_in) begin
            bundle.ch[n]   = CH_SLASH;
            bundle.kind[n] = KIND_CHAR;
            n = n + 2'd1;
         end
         bundle.ch[n]   = 8'd0;
         bundle.kind[n] = (mode_in == MODE_QUOTE || mode_in == MODE_BLOCK) ?
                          KIND_END_ERR : KIND_END_OK;
         n = n + 2'd1;
         mode_in  = MODE_NORMAL;
         quote_in = 8'd0;
         esc_in   = 1'b0;
         slash_in = 1'b0;
         star_in  = 1'b0;
      end

      bundle.cnt   = n;
      bundle_valid = accept && (n != 2'd0);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         mode_ff  <= MODE_NORMAL;
         quote_ff <= 8'd0;
         esc_ff   <= 1'b0;
         slash_ff <= 1'b0;
         star_ff  <= 1'b0;
      end else if (accept) begin
         mode_ff  <= mode_in;
         quote_ff <= quote_in;
         esc_ff   <= esc_in;
         slash_ff <= slash_in;
         star_ff  <= star_in;
      end
   end

endmodule

### hdl/scws_queue.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// scws_queue
// Two-entry bundle queue between the lexer and the result serializer.
// ----------------------------------------------------------------------------
module scws_queue (
   input  logic                clock,
   input  logic                reset,
   input  logic                wr_en,
   input  scws_pkg::bundle_type wr_data,
   output logic                full,
   input  logic                rd_en,
   output logic                rd_valid,
   output scws_pkg::bundle_type rd_data
);
   import scws_pkg::*;

   bundle_type entry_ff [2];
   logic       wr_ptr_ff, rd_ptr_ff;
   logic [1:0] count_ff;

   assign full     = (count_ff == 2'd2);
   assign rd_valid = (count_ff != 2'd0);
   assign rd_data  = entry_ff[rd_ptr_ff];

   always_ff @(posedge clock) begin
      if (wr_en) begin
         entry_ff[wr_ptr_ff] <= wr_data;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= 1'b0;
         rd_ptr_ff <= 1'b0;
         count_ff  <= 2'd0;
      end else begin
         if (wr_en) begin
            wr_ptr_ff <= ~wr_ptr_ff;
         end
         if (rd_en) begin
            rd_ptr_ff <= ~rd_ptr_ff;
         end
         case ({wr_en, rd_en})
            2'b10:   count_ff <= count_ff + 2'd1;
            2'b01:   count_ff <= count_ff - 2'd1;
            default: count_ff <= count_ff;
         endcase
      end
   end

endmodule

### hdl/scws_back.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// scws_back
// Result serializer: hands out the results of one bundle, one per pop.
// ----------------------------------------------------------------------------
module scws_back (
   input  logic                clock,
   input  logic                reset,
   input  logic                q_valid,
   input  scws_pkg::bundle_type q_data,
   output logic                q_pop,
   output logic                empty,
   input  logic                pop,
   output logic [7:0]          out_char,
   output logic [1:0]          kind,
   output logic                last_of_run
);
   import scws_pkg::*;

   bundle_type cur_ff;
   logic       valid_ff;
   logic [1:0] idx_ff;
   logic       take, done, load;

   assign empty       = !valid_ff;
   assign out_char    = cur_ff.ch[idx_ff];
   assign kind        = cur_ff.kind[idx_ff];
   assign last_of_run = (idx_ff == cur_ff.cnt - 2'd1);

   assign take  = valid_ff && pop;
   assign done  = take && last_of_run;
   assign load  = q_valid && (!valid_ff || done);
   assign q_pop = load;

   always_ff @(posedge clock) begin
      if (load) begin
         cur_ff <= q_data;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
         idx_ff   <= 2'd0;
      end else if (load) begin
         valid_ff <= 1'b1;
         idx_ff   <= 2'd0;
      end else if (done) begin
         valid_ff <= 1'b0;
         idx_ff   <= 2'd0;
      end else if (take) begin
         idx_ff   <= idx_ff + 2'd1;
      end
   end

`ifndef SYNTHESIS
   a_cnt_nonzero: assert property (@(posedge clock) disable iff (reset)
      valid_ff |-> (cur_ff.cnt != 2'd0))
      else $error("bundle with no results reached the serializer");

   a_idx_in_range: assert property (@(posedge clock) disable iff (reset)
      valid_ff |-> (idx_ff < cur_ff.cnt))
      else $error("result index beyond bundle count");

   a_end_is_last: assert property (@(posedge clock) disable iff (reset)
      (valid_ff && kind != KIND_CHAR) |-> last_of_run)
      else $error("end marker not last of its run");

   a_partial_advances: assert property (@(posedge clock) disable iff (reset)
      (take && !last_of_run) |=> (valid_ff && idx_ff == $past(idx_ff) + 2'd1))
      else $error("serializer lost its place inside a bundle");
`endif

endmodule

### hdl/source_comment_whitespace_stripper.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// source_comment_whitespace_stripper
// Strips C-style comments and whitespace outside quotes from a byte stream.
// ----------------------------------------------------------------------------
// Usage:
//   Input side is a queue write port: drive req_character / req_final_char
//   and raise req_push; the item is taken on a clock edge where req_full is
//   low. req_final_char marks the last byte of a source text.
//   Result side is a queue read port: while rsp_empty is low the oldest
//   result sits on rsp_out_char / rsp_kind / rsp_last_of_run, and rsp_pop
//   takes it. Each item causes zero to three results; the last byte of a
//   text always ends with an end marker (rsp_kind 1 ok, 2 unterminated).
// Timing:
//   The lexer classifies one item per cycle while req_full is low. Its
//   bundle is written to a two-entry queue at the edge that takes the
//   item and loaded into the serializer once the serializer is empty or
//   its last result is popped; the bundle's first result is then on the
//   rsp ports. The serializer hands out one result per cycle while
//   rsp_pop is high, so sustained rate is one item per cycle while items
//   average no more than one result; items with two or three results
//   take one pop per result. Items causing no result still need req_full low.
// Reset: synchronous; clears the lexer state, the queue and the serializer.
// Stall: if rsp_pop stays low, the queue fills and req_full rises; nothing
//   is dropped and the lexer state holds.
// ----------------------------------------------------------------------------
module source_comment_whitespace_stripper (
   input  logic       clock,
   input  logic       reset,
   input  logic       req_push,
   output logic       req_full,
   input  logic [7:0] req_character,
   input  logic       req_final_char,
   output logic       rsp_empty,
   input  logic       rsp_pop,
   output logic [7:0] rsp_out_char,
   output logic [1:0] rsp_kind,
   output logic       rsp_last_of_run
);
   import scws_pkg::*;

   logic       accept;
   logic       front_valid;
   bundle_type front_bundle;
   logic       q_valid;
   logic       q_pop;
   bundle_type q_data;

   // Item taken when the queue can hold its bundle, even if it yields nothing.
   assign accept = req_push && !req_full;

   scws_front u_front (
      .clock        (clock),
      .reset        (reset),
      .accept       (accept),
      .character    (req_character),
      .final_char   (req_final_char),
      .bundle_valid (front_valid),
      .bundle       (front_bundle)
   );

   scws_queue u_queue (
      .clock    (clock),
      .reset    (reset),
      .wr_en    (front_valid),
      .wr_data  (front_bundle),
      .full     (req_full),
      .rd_en    (q_pop),
      .rd_valid (q_valid),
      .rd_data  (q_data)
   );

   scws_back u_back (
      .clock       (clock),
      .reset       (reset),
      .q_valid     (q_valid),
      .q_data      (q_data),
      .q_pop       (q_pop),
      .empty       (rsp_empty),
      .pop         (rsp_pop),
      .out_char    (rsp_out_char),
      .kind        (rsp_kind),
      .last_of_run (rsp_last_of_run)
   );

endmodule
